FILE: hdl/sod_pkg.sv
// Shared types, constants and register codes for the sprite outline dilation block.
package sod_pkg;

  // Line memory depth, maximum height and the counter widths that follow from them.
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int LINE_AW    = $clog2(MAX_WIDTH);
  localparam int COL_W      = LINE_AW;
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int PEND_W     = LINE_AW + 1;

  // Configuration register widths and port format.
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_INDEX_W  = 1;
  localparam int WSPAN_W      = (WIDTH_REG_W > LINE_AW + 1) ? WIDTH_REG_W : LINE_AW + 1;

  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd16;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd16;

  // Output queue between the window stage and the master side.
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);

  // Window bit index is column * 3 + row; column 0 is the newest, row 0 the top.
  localparam logic [8:0] WIN_ALL       = 9'h1FF;
  localparam logic [8:0] WIN_CENTER    = 9'h010;
  localparam logic [8:0] WIN_TOP_ROW   = 9'h049;
  localparam logic [8:0] WIN_BOT_ROW   = 9'h124;
  localparam logic [8:0] WIN_RIGHT_COL = 9'h007;
  localparam logic [8:0] WIN_LEFT_COL  = 9'h1C0;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  localparam pixel_t WHITE_PIXEL = '{alpha: 8'hFF, blue: 8'hFF, green: 8'hFF, red: 8'hFF};
  localparam pixel_t BLACK_PIXEL = '{alpha: 8'hFF, blue: 8'h00, green: 8'h00, red: 8'h00};

  // Position flags of a slot, worked out when the pixel enters.
  typedef struct packed {
    logic valid;
    logic first_row;
    logic last_row;
    logic first_col;
    logic last_col;
  } tag_t;

  // One entry of the pixel line memory.
  typedef struct packed {
    tag_t   tag;
    pixel_t pix;
  } line_entry_t;

  // Slot handed from the front end to the window stage along with the memory reads.
  typedef struct packed {
    logic               valid;
    logic [LINE_AW-1:0] addr;
    logic               op;
    logic               rd_ok;
    logic               fwd;
    logic               fwd_op;
  } slot_t;

  typedef struct packed {
    logic   frame_end;
    pixel_t pix;
  } result_t;

endpackage

FILE: hdl/sod_ram.sv
// Simple dual-port synchronous RAM with registered, read-first output.
module sod_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read of the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/sod_window.sv
// Window stage: 3x3 opacity window, center pixel register and outline decision.
module sod_window (
  input  logic                       clk,
  input  logic                       clear,
  input  sod_pkg::slot_t             slot,
  input  sod_pkg::line_entry_t       pix_rd,
  input  logic                       op_rd,
  output logic                       op_we,
  output logic [sod_pkg::LINE_AW-1:0] op_waddr,
  output logic                       op_wdata,
  output logic                       prev_valid,
  output logic                       push,
  output sod_pkg::result_t           push_data
);

  logic [8:0]      window;
  logic [8:0]      window_next;
  sod_pkg::tag_t   center_tag;
  sod_pkg::pixel_t center_pix;
  sod_pkg::tag_t   old_tag;
  logic            old_op;
  logic            top_op;
  logic [8:0]      mask;

  // Data leaving the line memory; entries not yet written this run carry no tag.
  always_comb begin
    old_tag = slot.rd_ok ? pix_rd.tag : '0;
    old_op  = (pix_rd.pix.alpha != 8'h00);
    top_op  = slot.fwd ? slot.fwd_op : op_rd;
    window_next = {window[5:0], slot.op, old_op, top_op};
  end

  // The opacity line takes the opacity of the pixel leaving the pixel line.
  assign op_we    = slot.valid;
  assign op_waddr = slot.addr;
  assign op_wdata = old_op;

  // Tag of the slot before the one now entering; it decides whether that slot emits.
  assign prev_valid = slot.valid ? old_tag.valid : center_tag.valid;

  // Neighbors outside the image are dropped from the window.
  always_comb begin
    mask = sod_pkg::WIN_ALL & ~sod_pkg::WIN_CENTER;
    if (center_tag.first_row) begin
      mask = mask & ~sod_pkg::WIN_TOP_ROW;
    end
    if (center_tag.last_row) begin
      mask = mask & ~sod_pkg::WIN_BOT_ROW;
    end
    if (center_tag.last_col) begin
      mask = mask & ~sod_pkg::WIN_RIGHT_COL;
    end
    if (center_tag.first_col) begin
      mask = mask & ~sod_pkg::WIN_LEFT_COL;
    end
  end

  // Ink turns white, transparent pixels next to ink turn black.
  always_comb begin
    push = slot.valid && center_tag.valid;
    push_data.frame_end = center_tag.last_row && center_tag.last_col;
    if (center_pix.alpha != 8'h00) begin
      push_data.pix = sod_pkg::WHITE_PIXEL;
    end else if ((window_next & mask) != 9'h000) begin
      push_data.pix = sod_pkg::BLACK_PIXEL;
    end else begin
      push_data.pix = center_pix;
    end
  end

  // Window and center advance once per slot.
  always_ff @(posedge clk) begin
    if (clear) begin
      window     <= '0;
      center_tag <= '0;
    end else if (slot.valid) begin
      window     <= window_next;
      center_tag <= old_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (slot.valid) begin
      center_pix <= pix_rd.pix;
    end
  end

endmodule

FILE: hdl/sod_outq.sv
// Small output queue that decouples the window stage from the master side.
module sod_outq (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  sod_pkg::result_t            push_data,
  input  logic                        pop_ready,
  output logic                        out_valid,
  output sod_pkg::result_t            out_data,
  output logic [sod_pkg::OUTQ_AW:0]   count
);

  sod_pkg::result_t               mem [sod_pkg::OUTQ_DEPTH];
  logic [sod_pkg::OUTQ_AW-1:0]    wr_ptr;
  logic [sod_pkg::OUTQ_AW-1:0]    rd_ptr;
  logic [sod_pkg::OUTQ_AW:0]      count_next;
  logic                           pop;

  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];
  assign pop       = out_valid && pop_ready;

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + (sod_pkg::OUTQ_AW + 1)'(1);
    end else if (pop && !push) begin
      count_next = count - (sod_pkg::OUTQ_AW + 1)'(1);
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + sod_pkg::OUTQ_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + sod_pkg::OUTQ_AW'(1);
      end
      count <= count_next;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

FILE: hdl/sprite_outline_dilation.sv
// Top level of the sprite outline dilation block.
// Takes one RGBA pixel beat per clock in raster order while the output queue has room and returns
// pixels at the same rate: ink (nonzero alpha) becomes opaque white, a transparent pixel touching
// ink in its 8-neighborhood becomes opaque black, and anything else passes unchanged; neighbors
// outside the image count as absent. A pixel leaves after image_width + 1 further slots have
// entered and it has passed the line memory read and the window stage, so the tail of each frame
// is pushed out with flush beats (tuser high). The rate of one beat per cycle is set by the pixel
// line memory, which is read and written at one address per beat. Writing either size register
// restarts the block at the first pixel of a new frame; it needs no clearing pass.
module sprite_outline_dilation (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [31:0]                      s_axis_tdata,   // in_red, in_green, in_blue, in_alpha
  input  logic                             s_axis_tuser,   // flush
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [31:0]                      m_axis_tdata,   // out_red, out_green, out_blue, out_alpha
  output logic                             m_axis_tlast,
  input  logic                             cfg_we,
  input  logic [sod_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [sod_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [sod_pkg::WIDTH_REG_W-1:0]  width_reg;
  logic [sod_pkg::HEIGHT_REG_W-1:0] height_reg;
  logic [sod_pkg::WSPAN_W-1:0]      eff_w;
  logic [sod_pkg::WSPAN_W-1:0]      w_last;
  logic [sod_pkg::HEIGHT_REG_W-1:0] eff_h;
  logic [sod_pkg::HEIGHT_REG_W-1:0] h_last;
  logic                             clear;

  logic [sod_pkg::COL_W-1:0]   col_cnt, col_cnt_next;
  logic [sod_pkg::ROW_W-1:0]   row_cnt, row_cnt_next;
  logic [sod_pkg::LINE_AW-1:0] line_ptr, line_ptr_next;
  logic                        line_filled, line_filled_next;
  logic [sod_pkg::PEND_W-1:0]  pending, pending_next;
  logic [sod_pkg::PEND_W-1:0]  pend_inc;

  logic                        in_fire;
  logic                        is_flush;
  logic                        has_tag;
  logic                        take_slot;
  logic                        at_last_col;
  logic                        at_last_row;
  logic                        ptr_wrap;
  sod_pkg::line_entry_t        new_entry;
  sod_pkg::slot_t              slot, slot_next;

  logic [$bits(sod_pkg::line_entry_t)-1:0] pix_rd_bits;
  sod_pkg::line_entry_t        pix_rd;
  logic                        op_rd;
  logic                        op_we;
  logic [sod_pkg::LINE_AW-1:0] op_waddr;
  logic                        op_wdata;
  logic                        prev_valid;
  logic                        push;
  sod_pkg::result_t            push_data;
  sod_pkg::result_t            out_data;
  logic [sod_pkg::OUTQ_AW:0]   q_count;

  // Size registers; a write to either one starts a new frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= sod_pkg::WIDTH_RESET;
      height_reg <= sod_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        sod_pkg::CFG_IMAGE_WIDTH:  width_reg  <= cfg_data[sod_pkg::WIDTH_REG_W-1:0];
        sod_pkg::CFG_IMAGE_HEIGHT: height_reg <= cfg_data[sod_pkg::HEIGHT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  assign clear = rst || (cfg_we && (cfg_index == sod_pkg::CFG_IMAGE_WIDTH ||
                                    cfg_index == sod_pkg::CFG_IMAGE_HEIGHT));

  // Sizes clamped to the supported range.
  always_comb begin
    if (width_reg == '0) begin
      eff_w = sod_pkg::WSPAN_W'(1);
    end else if (sod_pkg::WSPAN_W'(width_reg) > sod_pkg::WSPAN_W'(sod_pkg::MAX_WIDTH)) begin
      eff_w = sod_pkg::WSPAN_W'(sod_pkg::MAX_WIDTH);
    end else begin
      eff_w = sod_pkg::WSPAN_W'(width_reg);
    end
    if (height_reg == '0) begin
      eff_h = sod_pkg::HEIGHT_REG_W'(1);
    end else if (height_reg > sod_pkg::HEIGHT_REG_W'(sod_pkg::MAX_HEIGHT)) begin
      eff_h = sod_pkg::HEIGHT_REG_W'(sod_pkg::MAX_HEIGHT);
    end else begin
      eff_h = height_reg;
    end
    w_last = eff_w - sod_pkg::WSPAN_W'(1);
    h_last = eff_h - sod_pkg::HEIGHT_REG_W'(1);
  end

  // Input beat decode: a flush at a frame boundary only makes a slot while pixels are pending.
  always_comb begin
    in_fire     = s_axis_tvalid && s_axis_tready;
    is_flush    = s_axis_tuser;
    has_tag     = !is_flush || (col_cnt != '0) || (row_cnt != '0);
    take_slot   = in_fire && (has_tag || (pending != '0));
    at_last_col = (sod_pkg::WSPAN_W'(col_cnt) == w_last);
    at_last_row = (sod_pkg::HEIGHT_REG_W'(row_cnt) == h_last);
    ptr_wrap    = (sod_pkg::WSPAN_W'(line_ptr) == w_last);

    new_entry.pix = is_flush ? '0 : sod_pkg::pixel_t'(s_axis_tdata);
    new_entry.tag = '0;
    if (has_tag) begin
      new_entry.tag.valid     = 1'b1;
      new_entry.tag.first_row = (row_cnt == '0);
      new_entry.tag.last_row  = at_last_row;
      new_entry.tag.first_col = (col_cnt == '0);
      new_entry.tag.last_col  = at_last_col;
    end
  end

  // Raster position, line pointer, fill flag and pending count for the next slot.
  always_comb begin
    col_cnt_next     = col_cnt;
    row_cnt_next     = row_cnt;
    line_ptr_next    = line_ptr;
    line_filled_next = line_filled;
    pending_next     = pending;
    pend_inc         = pending + sod_pkg::PEND_W'(has_tag);
    if (take_slot) begin
      if (has_tag) begin
        if (at_last_col) begin
          col_cnt_next = '0;
          row_cnt_next = at_last_row ? '0 : row_cnt + sod_pkg::ROW_W'(1);
        end else begin
          col_cnt_next = col_cnt + sod_pkg::COL_W'(1);
        end
      end
      if (ptr_wrap) begin
        line_ptr_next    = '0;
        line_filled_next = 1'b1;
      end else begin
        line_ptr_next = line_ptr + sod_pkg::LINE_AW'(1);
      end
      if (prev_valid && (pend_inc != '0)) begin
        pending_next = pend_inc - sod_pkg::PEND_W'(1);
      end else begin
        pending_next = pend_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      col_cnt     <= '0;
      row_cnt     <= '0;
      line_ptr    <= '0;
      line_filled <= 1'b0;
      pending     <= '0;
    end else begin
      col_cnt     <= col_cnt_next;
      row_cnt     <= row_cnt_next;
      line_ptr    <= line_ptr_next;
      line_filled <= line_filled_next;
      pending     <= pending_next;
    end
  end

  // Slot register beside the memory reads; forwards an opacity write to the same entry.
  always_comb begin
    slot_next.valid  = take_slot;
    slot_next.addr   = line_ptr;
    slot_next.op     = !is_flush && (s_axis_tdata[31:24] != 8'h00);
    slot_next.rd_ok  = line_filled;
    slot_next.fwd    = op_we && (op_waddr == line_ptr);
    slot_next.fwd_op = op_wdata;
  end

  // Only the valid flag is cleared; the other fields are used while it is set.
  always_ff @(posedge clk) begin
    if (clear) begin
      slot.valid <= 1'b0;
    end else begin
      slot.valid <= slot_next.valid;
    end
    slot.addr   <= slot_next.addr;
    slot.op     <= slot_next.op;
    slot.rd_ok  <= slot_next.rd_ok;
    slot.fwd    <= slot_next.fwd;
    slot.fwd_op <= slot_next.fwd_op;
  end

  // Pixel line: the new pixel replaces the one from a row earlier at the same address.
  sod_ram #(
    .WIDTH ($bits(sod_pkg::line_entry_t)),
    .DEPTH (sod_pkg::MAX_WIDTH)
  ) u_pix_ram (
    .clk   (clk),
    .we    (take_slot),
    .waddr (line_ptr),
    .wdata (new_entry),
    .re    (take_slot),
    .raddr (line_ptr),
    .rdata (pix_rd_bits)
  );

  assign pix_rd = sod_pkg::line_entry_t'(pix_rd_bits);

  // Opacity line: one row further back, written in the cycle after the pixel line is read.
  sod_ram #(
    .WIDTH (1),
    .DEPTH (sod_pkg::MAX_WIDTH)
  ) u_op_ram (
    .clk   (clk),
    .we    (op_we),
    .waddr (op_waddr),
    .wdata (op_wdata),
    .re    (take_slot),
    .raddr (line_ptr),
    .rdata (op_rd)
  );

  sod_window u_window (
    .clk        (clk),
    .clear      (clear),
    .slot       (slot),
    .pix_rd     (pix_rd),
    .op_rd      (op_rd),
    .op_we      (op_we),
    .op_waddr   (op_waddr),
    .op_wdata   (op_wdata),
    .prev_valid (prev_valid),
    .push       (push),
    .push_data  (push_data)
  );

  sod_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (out_data),
    .count     (q_count)
  );

  // Accept only while the queue has room for everything already in the pipeline.
  assign s_axis_tready = ((q_count + (sod_pkg::OUTQ_AW + 1)'(slot.valid)) <
                          (sod_pkg::OUTQ_AW + 1)'(sod_pkg::OUTQ_DEPTH));

  assign m_axis_tdata = out_data.pix;
  assign m_axis_tlast = out_data.frame_end;

endmodule

FILE: hdl/sod_checker.sv
// Port-level checker for the sprite outline dilation block and its bind.
module sod_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // Nothing is offered right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // With the output side empty the block is always able to take a beat.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output is empty");

  // A result on an empty output stems from a beat that passed the slot register.
  a_result_follows_input: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result without a preceding input beat");

  // Results are white, opaque black, or a transparent pixel passed through.
  a_result_colors: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[31:24] == 8'h00 ||
                       (m_axis_tdata[31:24] == 8'hFF &&
                        (m_axis_tdata[23:0] == 24'hFFFFFF || m_axis_tdata[23:0] == 24'h000000))))
    else $error("result pixel is neither outline, ink nor transparent");

  // A stalled result beat holds.
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output beat changed while stalled");

endmodule

bind sprite_outline_dilation sod_checker u_sod_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
